/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("concurrent assertion failed");

// Clocked assertion on the block's usual clock and reset.
`define ASSERT_STD(name, prop) \
  `ASSERT_CLK(name, clk_i, rst_ni, prop)

`endif

/* sv/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Types, constants and codes shared by the square dilation block.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Default store and window limits
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_RADIUS = 15;

  // Fixed field widths
  localparam int COORD_IN_W = 6;
  localparam int RADIUS_W   = 4;
  localparam int FRAME_W    = 7;
  localparam int AREA_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 8;

  // Input beat layout in tdata
  localparam int COL_LSB = 0;
  localparam int ROW_LSB = COL_LSB + COORD_IN_W;
  localparam int PIX_BIT = ROW_LSB + COORD_IN_W;

  // Command carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS       = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_AREA_LEFT    = 3'd3,
    REG_AREA_TOP     = 3'd4,
    REG_AREA_RIGHT   = 3'd5,
    REG_AREA_BOTTOM  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;   // input beat accepted this cycle
    logic setup;  // latch window bounds and column mask
    logic rd;     // read the current window row
    logic load;   // load the result into the output register
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;  // offered beat is a query
    logic in_area;   // latched query lies inside frame and area
    logic last_row;  // current row is the window's last
    logic out_free;  // output register can take a result
  } stat_t;

endpackage

/* sv/bsd_ctrl.sv */
// ----------------------------------------------------------------------------
// bsd_ctrl
// Sequencer: take input beats; for a query set up the window, sweep its rows, emit.
// ----------------------------------------------------------------------------
module bsd_ctrl import bsd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    ctrl_o        = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl_o.take   = s_axis_tvalid;
        if (s_axis_tvalid && stat_i.is_query) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        ctrl_o.setup = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        if (!stat_i.in_area) begin
          state_d = ST_DRAIN;
        end else begin
          ctrl_o.rd = 1'b1;
          if (stat_i.last_row) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // hold until the output register is free
        if (stat_i.out_free) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/bsd_datapath.sv */
// ----------------------------------------------------------------------------
// bsd_datapath
// Bitmap store, configuration, window bounds, row accumulator, output reg.
// ----------------------------------------------------------------------------
module bsd_datapath import bsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  ctrl_t                  ctrl_i,
  output stat_t                  stat_o
);

  localparam int WLOG = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int HLOG = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BIG  = (WLOG > HLOG) ? WLOG : HLOG;
  localparam int CW   = ((BIG > 7) ? BIG : 7) + 1;

  // Configuration
  logic [RADIUS_W-1:0] radius_q;
  logic [FRAME_W-1:0]  fw_q, fh_q;
  logic [AREA_W-1:0]   al_q, at_q, ar_q, ab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_W'(1);
      fw_q     <= FRAME_W'(64);
      fh_q     <= FRAME_W'(64);
      al_q     <= '0;
      at_q     <= '0;
      ar_q     <= AREA_W'(63);
      ab_q     <= AREA_W'(63);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RADIUS:       radius_q <= cfg_wdata_i[RADIUS_W-1:0];
        REG_FRAME_WIDTH:  fw_q     <= cfg_wdata_i[FRAME_W-1:0];
        REG_FRAME_HEIGHT: fh_q     <= cfg_wdata_i[FRAME_W-1:0];
        REG_AREA_LEFT:    al_q     <= cfg_wdata_i[AREA_W-1:0];
        REG_AREA_TOP:     at_q     <= cfg_wdata_i[AREA_W-1:0];
        REG_AREA_RIGHT:   ar_q     <= cfg_wdata_i[AREA_W-1:0];
        REG_AREA_BOTTOM:  ab_q     <= cfg_wdata_i[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // Input beat fields
  logic [CW-1:0] col_x, row_x;
  logic          pix;
  assign col_x = CW'(s_axis_tdata[COL_LSB +: COORD_IN_W]);
  assign row_x = CW'(s_axis_tdata[ROW_LSB +: COORD_IN_W]);
  assign pix   = s_axis_tdata[PIX_BIT];
  assign stat_o.is_query = (s_axis_tuser == CMD_QUERY);

  // Bitmap store, one row per word
  logic [MAX_WIDTH-1:0] bitmap_q [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rdata_q;
  logic                 we;
  logic [CW-1:0]        y_q, y1_q;

  assign we = ctrl_i.take && (s_axis_tuser == CMD_WRITE)
              && (col_x < CW'(MAX_WIDTH)) && (row_x < CW'(MAX_HEIGHT));

  always_ff @(posedge clk_i) begin
    if (we) begin
      bitmap_q[row_x[HLOG-1:0]][col_x[WLOG-1:0]] <= pix;
    end
    if (ctrl_i.rd) begin
      rdata_q <= bitmap_q[y_q[HLOG-1:0]];
    end
  end

  // Latched query coordinates
  logic [CW-1:0] qc_q, qr_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && stat_o.is_query) begin
      qc_q <= col_x;
      qr_q <= row_x;
    end
  end

  // Window bounds from the latched query
  logic [CW-1:0] w, h, d, fw_x, fh_x, rad_x;
  logic [CW-1:0] x0, x1, y0, y1, cpd, rpd;
  logic          in_area;
  logic [MAX_WIDTH-1:0] mask;

  always_comb begin
    fw_x  = CW'(fw_q);
    fh_x  = CW'(fh_q);
    rad_x = CW'(radius_q);
    w = (fw_x == '0) ? CW'(1) : ((fw_x > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : fw_x);
    h = (fh_x == '0) ? CW'(1) : ((fh_x > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : fh_x);
    d = (rad_x > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : rad_x;
    in_area = (qc_q < w) && (qr_q < h)
              && (qc_q >= CW'(al_q)) && (qc_q <= CW'(ar_q))
              && (qr_q >= CW'(at_q)) && (qr_q <= CW'(ab_q));
    cpd = qc_q + d;
    rpd = qr_q + d;
    x0  = (qc_q >= d) ? (qc_q - d) : '0;
    y0  = (qr_q >= d) ? (qr_q - d) : '0;
    x1  = (cpd > (w - CW'(1))) ? (w - CW'(1)) : cpd;
    y1  = (rpd > (h - CW'(1))) ? (h - CW'(1)) : rpd;
    mask = ({MAX_WIDTH{1'b1}} << x0) & ({MAX_WIDTH{1'b1}} >> (CW'(MAX_WIDTH - 1) - x1));
  end

  logic                 in_area_q, rv_q, acc_q, hit, result;
  logic [MAX_WIDTH-1:0] mask_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      in_area_q <= in_area;
      y1_q      <= y1;
      mask_q    <= mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.setup) begin
      y_q <= y0;
    end else if (ctrl_i.rd) begin
      y_q <= y_q + CW'(1);
    end
  end

  assign hit    = rv_q && (|(rdata_q & mask_q));
  assign result = acc_q | hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      acc_q <= 1'b0;
    end else begin
      rv_q  <= ctrl_i.rd;
      acc_q <= ctrl_i.setup ? 1'b0 : result;
    end
  end

  assign stat_o.in_area  = in_area_q;
  assign stat_o.last_row = (y_q == y1_q);

  // Output register
  logic out_valid_q, out_bit_q;
  assign stat_o.out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_bit_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_bit_q);

endmodule

/* sv/binary_square_dilation.sv */
// ----------------------------------------------------------------------------
// binary_square_dilation
// Binary dilation of a stored bitmap by a square window of set radius.
// ----------------------------------------------------------------------------
// Input beats either write one source pixel (tuser low) or query one dilated
// pixel (tuser high). After a write the block is ready again in the next
// cycle. A query steps through states up to the next ready: ST_IDLE takes the
// beat, ST_SETUP works out the clamped window and its column mask, ST_READ
// reads the window rows one at a time through the single read port of the
// bitmap store (at most 2*MAX_RADIUS+1 rows, 31 with the defaults), and
// ST_DRAIN folds in the last row and loads the output register; ST_DRAIN is
// held while an earlier result still waits for the sink. A query outside the
// frame or the allowed area reads no row and answers 0. The result sits in an
// output register, so the next beat is taken while it waits for the sink. The
// store has no reset; only pixels already written may fall inside a queried window.
// The user must write configuration through cfg_we_i / cfg_idx_i /
// cfg_wdata_i only while the block idles; the block does not enforce this.
module binary_square_dilation import bsd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // col[5:0], row[11:6], pixel_in[12]
  input  logic                   s_axis_tuser,   // cmd
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // dilated[0]
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer: takes beats, steps through the window rows, hands over results
  bsd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .ctrl_o        (ctrl)
  );

  // Store, window arithmetic and result register
  bsd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .ctrl_i        (ctrl),
    .stat_o        (stat)
  );

endmodule

/* sv/bsd_checker.sv */
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level assertions for the square dilation block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsd_checker import bsd_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result stays offered and unchanged
  `ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `ASSERT_STD(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  // Only the dilated bit may be set
  `ASSERT_STD(a_out_pad, m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0))
  // A query beat keeps the block busy for the next cycle
  `ASSERT_STD(a_query_busy,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
  // A write beat leaves the block ready
  `ASSERT_STD(a_write_ready,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE) |=> s_axis_tready)

endmodule

bind binary_square_dilation bsd_checker u_bsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/binary_square_dilation_tb.sv */
// ----------------------------------------------------------------------------
// binary_square_dilation_tb
// Self-checking bench for the square-window binary dilation block.
// ----------------------------------------------------------------------------
// Pixel writes and dilated-pixel queries are streamed into the block. A bench
// copy of the bitmap and of the window settings predicts each query's answer,
// and the answers coming back are compared in order. A short fixed table runs
// first under the reset settings. A series of window, frame and area settings
// follows, the corner cases first and random ones after. Every pixel that a
// query's window covers is written before the query is sent. Sender gaps and
// sink stalls change from one setting to the next.
// ----------------------------------------------------------------------------
module binary_square_dilation_tb import bsd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1950;
  localparam int SETTLE_CYCLES  = 40;    // longer than one query through the block
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat, no write

  // Index beyond the register list: the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Window, frame and area settings, held as written (saturation is applied
  // when a window is worked out, as the block does)
  typedef struct {
    int unsigned radius;
    int unsigned width;
    int unsigned height;
    int unsigned left;
    int unsigned top;
    int unsigned right;
    int unsigned bottom;
  } dil_cfg_t;

  // One row of the fixed opening sequence
  typedef struct packed {
    logic       cmd;
    logic [5:0] col;
    logic [5:0] row;
    logic       pix;
    logic       typed;      // answer written into the table
    logic       typed_val;
  } probe_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // col[5:0], row[11:6], pixel_in[12]
  logic                   s_axis_tuser  = 1'b0; // cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // dilated[0]

  // Bench copy of the bitmap, and which pixels have been written so far
  bit pixel_store [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
  bit pixel_known [DEF_MAX_HEIGHT][DEF_MAX_WIDTH];
  dil_cfg_t cfg_now = '{1, 64, 64, 0, 0, 63, 63};

  bit dilated_due [$];   // predicted answers, oldest first
  int beats_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int one_pct       = 10; // share of written pixels that are set

  // Under the reset settings: radius 1 over the full 64 x 64 frame
  probe_row_t probe_table [17] = '{
    '{CMD_WRITE, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd62, 6'd63, 1'b0, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd63, 6'd62, 1'b0, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd62, 6'd62, 1'b1, 1'b0, 1'b0},
    '{CMD_QUERY, 6'd63, 6'd63, 1'b0, 1'b1, 1'b1},  // far corner sees the diagonal
    '{CMD_WRITE, 6'd62, 6'd62, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},  // cleared; pixel_in ignored
    '{CMD_WRITE, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd1,  6'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd1,  6'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 6'd0,  6'd0,  1'b1, 1'b1, 1'b1},  // origin, window clamped
    '{CMD_WRITE, 6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0},
    '{CMD_WRITE, 6'd2,  6'd0,  1'b1, 1'b0, 1'b0},
    '{CMD_WRITE, 6'd2,  6'd1,  1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 6'd1,  6'd0,  1'b0, 1'b0, 1'b0}   // left to the predictor
  };

  // Corner settings: zero and oversize frames, widest window, empty and
  // off-frame areas, then an ordinary area inside a small frame
  dil_cfg_t corner_cfgs [7] = '{
    '{0,  0,   0,   0,  0,  63, 63},
    '{15, 127, 0,   0,  0,  63, 63},
    '{15, 2,   127, 0,  0,  63, 63},
    '{2,  10,  12,  5,  0,  3,  11},
    '{1,  12,  10,  0,  7,  11, 2},
    '{3,  8,   8,   20, 20, 40, 40},
    '{1,  16,  16,  4,  4,  11, 11}
  };

  binary_square_dilation DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Saturate a frame size into 1..hi; zero acts as one
  function automatic int frame_clamp(int unsigned v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Clipped window of a query; zero when the query lies outside frame or area
  function automatic bit window_of(int c, int r, output int x0, output int x1,
                                   output int y0, output int y1);
    int w, h, d, ax1, ay1;
    w   = frame_clamp(cfg_now.width, DEF_MAX_WIDTH);
    h   = frame_clamp(cfg_now.height, DEF_MAX_HEIGHT);
    d   = (cfg_now.radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : cfg_now.radius;
    ax1 = (cfg_now.right < w - 1) ? cfg_now.right : w - 1;
    ay1 = (cfg_now.bottom < h - 1) ? cfg_now.bottom : h - 1;
    x0 = 0; x1 = 0; y0 = 0; y1 = 0;
    if (c >= w || r >= h) return 1'b0;
    if (c < cfg_now.left || c > ax1 || r < cfg_now.top || r > ay1) return 1'b0;
    x0 = (c - d < 0) ? 0 : c - d;
    y0 = (r - d < 0) ? 0 : r - d;
    x1 = (c + d > w - 1) ? w - 1 : c + d;
    y1 = (r + d > h - 1) ? h - 1 : r + d;
    return 1'b1;
  endfunction

  function automatic bit predict_dilated(int c, int r);
    int x0, x1, y0, y1;
    if (!window_of(c, r, x0, x1, y0, y1)) return 1'b0;
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++)
        if (pixel_store[y][x]) return 1'b1;
    return 1'b0;
  endfunction

  // Track a register write; unknown indexes change nothing
  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    case (idx)
      REG_RADIUS:       cfg_now.radius = v & ((1 << RADIUS_W) - 1);
      REG_FRAME_WIDTH:  cfg_now.width  = v & ((1 << FRAME_W) - 1);
      REG_FRAME_HEIGHT: cfg_now.height = v & ((1 << FRAME_W) - 1);
      REG_AREA_LEFT:    cfg_now.left   = v & ((1 << AREA_W) - 1);
      REG_AREA_TOP:     cfg_now.top    = v & ((1 << AREA_W) - 1);
      REG_AREA_RIGHT:   cfg_now.right  = v & ((1 << AREA_W) - 1);
      REG_AREA_BOTTOM:  cfg_now.bottom = v & ((1 << AREA_W) - 1);
      default: ;
    endcase
  endfunction

  // Hold the enable high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    logic [CFG_DATA_W-1:0] data;
    data = v[CFG_DATA_W-1:0];
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    store_reg(idx, data);
  endtask

  task automatic program_setting(dil_cfg_t s);
    write_reg(REG_SPARE, $urandom_range(127));
    write_reg(REG_RADIUS, s.radius);
    write_reg(REG_FRAME_WIDTH, s.width);
    write_reg(REG_FRAME_HEIGHT, s.height);
    write_reg(REG_AREA_LEFT, s.left);
    write_reg(REG_AREA_TOP, s.top);
    write_reg(REG_AREA_RIGHT, s.right);
    write_reg(REG_AREA_BOTTOM, s.bottom);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one beat, with a random gap ahead of it, and hold it until taken.
  // The prediction is made at acceptance, so later writes cannot disturb it.
  task automatic send_beat(logic cmd, int col, int row, logic pix,
                           logic typed = 1'b0, logic typed_val = 1'b0);
    logic [IN_TDATA_W-1:0] beat;
    beat = '0;
    beat[COL_LSB +: COORD_IN_W] = COORD_IN_W'(col);
    beat[ROW_LSB +: COORD_IN_W] = COORD_IN_W'(row);
    beat[PIX_BIT] = pix;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    beats_sent++;
    if (cmd == CMD_WRITE) begin
      pixel_store[row][col] = pix;
      pixel_known[row][col] = 1'b1;
    end else begin
      dilated_due.push_back(typed ? typed_val : predict_dilated(col, row));
    end
  endtask

  // Write every not yet written pixel that the window covers, then query
  task automatic issue_query(int col, int row);
    int x0, x1, y0, y1;
    if (window_of(col, row, x0, x1, y0, y1)) begin
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          if (!pixel_known[y][x])
            send_beat(CMD_WRITE, x, y, $urandom_range(99) < one_pct);
    end
    send_beat(CMD_QUERY, col, row, 1'($urandom_range(1)));
  endtask

  // Drop valid, wait for every outstanding answer, then hold a while longer
  task automatic settle(int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (dilated_due.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic dil_cfg_t random_setting();
    dil_cfg_t s;
    int sel, w, h;
    s.radius = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
    sel = $urandom_range(9);
    s.width  = (sel < 6) ? $urandom_range(1, 16) : (sel < 8) ? 64 : $urandom_range(127);
    sel = $urandom_range(9);
    s.height = (sel < 6) ? $urandom_range(1, 16) : (sel < 8) ? 64 : $urandom_range(127);
    w = frame_clamp(s.width, DEF_MAX_WIDTH);
    h = frame_clamp(s.height, DEF_MAX_HEIGHT);
    // keep big windows to small frames, or a single query fills the store
    if (w * h > 256) s.radius = $urandom_range(2);
    sel = $urandom_range(19);
    if (sel < 10) begin
      s.left = 0; s.top = 0; s.right = 63; s.bottom = 63;
    end else if (sel < 17) begin
      s.left   = $urandom_range(w - 1);
      s.right  = $urandom_range(w - 1, s.left);
      s.top    = $urandom_range(h - 1);
      s.bottom = $urandom_range(h - 1, s.top);
    end else begin
      s.left   = $urandom_range(63);
      s.right  = $urandom_range(63);
      s.top    = $urandom_range(63);
      s.bottom = $urandom_range(63);
    end
    return s;
  endfunction

  // Wait for the block to idle, apply the setting and pick the pacing:
  // no idling, sender gaps, sink stalls, then both
  task automatic begin_phase(dil_cfg_t s, int phase_no);
    int pick;
    settle(SETTLE_CYCLES);
    program_setting(s);
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 71; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 71; end
      default: begin send_idle_pct = 34; stall_pct = 34; end
    endcase
    pick = $urandom_range(3);
    one_pct = (pick == 0) ? 3 : (pick == 1) ? 10 : (pick == 2) ? 25 : 50;
  endtask

  // Mostly writes and queries inside the frame and area, some anywhere
  task automatic run_phase(int n);
    int w, h, ax1, ay1, roll, c, r;
    w   = frame_clamp(cfg_now.width, DEF_MAX_WIDTH);
    h   = frame_clamp(cfg_now.height, DEF_MAX_HEIGHT);
    ax1 = (cfg_now.right < w - 1) ? cfg_now.right : w - 1;
    ay1 = (cfg_now.bottom < h - 1) ? cfg_now.bottom : h - 1;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        send_beat(CMD_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
                  $urandom_range(99) < one_pct);
      end else if (roll < 42) begin
        send_beat(CMD_WRITE, $urandom_range(63), $urandom_range(63),
                  1'($urandom_range(1)));
      end else if (roll < 50) begin
        issue_query($urandom_range(63), $urandom_range(63));
      end else if (roll < 52) begin
        settle(0);
      end else begin
        if (cfg_now.left <= ax1 && cfg_now.top <= ay1) begin
          c = $urandom_range(ax1, cfg_now.left);
          r = $urandom_range(ay1, cfg_now.top);
        end else begin
          c = $urandom_range(w - 1);
          r = $urandom_range(h - 1);
        end
        issue_query(c, r);
      end
    end
  endtask

  // Sink: stall at random, check each answer against the oldest prediction,
  // and end the run when nothing moves for too long
  always @(posedge clk_i) begin : sink
    bit want;
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (dilated_due.size() == 0) begin
        report_mismatch($sformatf("answer %0d arrived with no query waiting (dilated=%0b)",
                                  results_seen, m_axis_tdata[0]));
      end else begin
        want = dilated_due.pop_front();
        if (m_axis_tdata[0] !== want)
          report_mismatch($sformatf("answer %0d: dilated=%0b, predicted %0b",
                                    results_seen, m_axis_tdata[0], want));
      end
      results_seen++;
    end
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase_no;
    phase_no = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Opening table under the reset settings, no idling
    foreach (probe_table[i])
      send_beat(probe_table[i].cmd, probe_table[i].col, probe_table[i].row,
                probe_table[i].pix, probe_table[i].typed, probe_table[i].typed_val);

    foreach (corner_cfgs[i]) begin
      begin_phase(corner_cfgs[i], phase_no);
      phase_no++;
      run_phase(30);
    end

    while (beats_sent < ITEM_TARGET) begin
      begin_phase(random_setting(), phase_no);
      phase_no++;
      run_phase($urandom_range(40, 160));
    end

    settle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
